[rtl/tile_binning_dirty_tracker_unit_assert.svh]
// assertion macros for the tile binning dirty tracker
`ifndef TILE_BINNING_DIRTY_TRACKER_UNIT_ASSERT_SVH
`define TILE_BINNING_DIRTY_TRACKER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define TBDT_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define TBDT_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tbdt_pkg.sv]
// shared types and constants for the tile binning dirty tracker
package tbdt_pkg;

   localparam int TILE_W_DEF     = 16;
   localparam int TILE_H_DEF     = 16;
   localparam int MAX_TILES_DEF  = 2048;
   localparam int SLOTS_DEF      = 32;

   localparam int CW             = 13;   // canvas coordinate width
   localparam int DIV_W          = CW + 1;
   localparam int DCNT_W         = 4;
   localparam int FIELD_W        = 16;
   localparam int TILE_FIELD_W   = 11;
   localparam int SLOT_FIELD_W   = 5;
   localparam int COUNT_FIELD_W  = 6;
   localparam int CSR_IDX_W      = 1;

   localparam logic [CW-1:0] CANVAS_W_RESET = 13'd640;
   localparam logic [CW-1:0] CANVAS_H_RESET = 13'd480;

   typedef enum logic [1:0] {
      FUNC_DRAW,
      FUNC_UPDATE,
      FUNC_READ,
      FUNC_REDRAW_ALL
   } func_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_EMPTY,
      ST_CLIPPED,
      ST_OVERFLOW
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_CANVAS_WIDTH,
      REG_CANVAS_HEIGHT
   } csr_reg_type;

endpackage

[rtl/tbdt_ifs.sv]
// channel interfaces: request, response and register write
interface tbdt_req_if
   import tbdt_pkg::*;
   ;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    func;
   logic signed [FIELD_W-1:0]     pos_x;
   logic signed [FIELD_W-1:0]     pos_y;
   logic signed [FIELD_W-1:0]     anchor_x;
   logic signed [FIELD_W-1:0]     anchor_y;
   logic signed [FIELD_W-1:0]     obj_width;
   logic signed [FIELD_W-1:0]     obj_height;
   logic                          obj_dirty;
   logic [FIELD_W-1:0]            object_id;
   logic [TILE_FIELD_W-1:0]       tile_index;
   logic [SLOT_FIELD_W-1:0]       slot;

   modport source (output valid, func, pos_x, pos_y, anchor_x, anchor_y, obj_width,
                   obj_height, obj_dirty, object_id, tile_index, slot, input ready);
   modport sink (input valid, func, pos_x, pos_y, anchor_x, anchor_y, obj_width,
                 obj_height, obj_dirty, object_id, tile_index, slot, output ready);
endinterface

interface tbdt_rsp_if
   import tbdt_pkg::*;
   ;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    status;
   logic                          redraw;
   logic [COUNT_FIELD_W-1:0]      entry_count;
   logic [FIELD_W-1:0]            entry_object;
   logic signed [FIELD_W-1:0]     entry_x;
   logic signed [FIELD_W-1:0]     entry_y;

   modport source (output valid, status, redraw, entry_count, entry_object, entry_x,
                   entry_y, input ready);
   modport sink (input valid, status, redraw, entry_count, entry_object, entry_x,
                 entry_y, output ready);
endinterface

interface tbdt_csr_if
   import tbdt_pkg::*;
   ;
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CW-1:0]          data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/tbdt_ram.sv]
// generic simple dual-port ram with registered read
module tbdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

[rtl/tile_binning_dirty_tracker_unit.sv]
// tile binning dirty tracker: top level with sequencer, divider and tile memories
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+----------------------------------------------
//  req_    | in  | valid / ready   | func, position, anchor, size, dirty, id, tile, slot
//  rsp_    | out | valid / ready   | status, redraw, entry_count, entry object/x/y
//  csr_    | in  | valid / ready   | register index, write data (ready always high)
//
//  one transaction at a time; steps from accept to result in the output register: update
//  query reads then writes count and last; entry read waits on the entry memory; slot 0
//  read finds tiles per row by reciprocal multiply, then runs the 14-step divider for
//  tile / tiles per row; rejected draw goes from decode to the result; draw runs five
//  constant divides and row base, then reads and writes each covered tile; redraw all
//  sweeps last-count memory; after reset a clearing pass fills count and last memories
//  a result waits in the output register; the next transaction is taken meanwhile
module tile_binning_dirty_tracker_unit
   import tbdt_pkg::*;
#(
   parameter int TILE_W         = TILE_W_DEF,
   parameter int TILE_H         = TILE_H_DEF,
   parameter int MAX_TILES      = MAX_TILES_DEF,
   parameter int SLOTS_PER_TILE = SLOTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tbdt_req_if.sink   req_chan,
   tbdt_rsp_if.source rsp_chan,
   tbdt_csr_if.sink   csr_chan
);

   localparam int TIDX_W    = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int CNT_W     = $clog2(SLOTS_PER_TILE + 1);
   localparam int ENT_DEPTH = MAX_TILES * SLOTS_PER_TILE;
   localparam int EA_W      = $clog2(ENT_DEPTH);
   localparam int ENT_W     = 3 * FIELD_W;
   localparam int LIN_W     = 2 * CW;
   // reciprocal for division by the tile size; exact for tile sizes up to 256
   localparam int RCP_SH    = DIV_W + 8;
   localparam int PROD_W    = DIV_W + RCP_SH;
   localparam logic [RCP_SH-1:0] RCP_TW = RCP_SH'((2**RCP_SH + TILE_W - 1) / TILE_W);
   localparam logic [RCP_SH-1:0] RCP_TH = RCP_SH'((2**RCP_SH + TILE_H - 1) / TILE_H);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_CDIV, S_DIV, S_DIV_NEXT, S_ROWBASE, S_TILE_RD,
      S_TILE_WR, S_UPD_WR, S_ENT_WAIT, S_SWEEP, S_DONE
   } state_type;

   typedef enum logic [2:0] {
      J_TPR, J_TX0, J_TX1, J_TY0, J_TY1, J_TILE
   } job_type;

   state_type state_ff;
   job_type   job_ff;

   // configuration
   logic [CW-1:0] width_ff, height_ff;

   // latched transaction
   func_type                func_ff;
   logic signed [CW+3:0]    x_ff, y_ff;
   logic signed [FIELD_W-1:0] w_ff, h_ff;
   logic                    dirty_ff;
   logic [FIELD_W-1:0]      id_ff;
   logic [TILE_FIELD_W-1:0] tile_ff;
   logic [SLOT_FIELD_W-1:0] slot_ff;

   // clipped rectangle and tile walk
   logic [CW-1:0]    left_ff, right_ff, top_ff, bottom_ff;
   logic [CW-1:0]    tpr_ff, tx0_ff, tx1_ff, ty1_ff, tx_ff, ty_ff;
   logic [LIN_W-1:0] row_base_ff;
   logic [TIDX_W-1:0] idx_ff, sweep_ff;

   // divider
   logic [DIV_W-1:0]  num_ff;
   logic [CW-1:0]     den_ff, rem_ff;
   logic [DCNT_W-1:0] dcnt_ff;

   // pending result and output register
   status_type               res_status_ff;
   logic                     res_redraw_ff;
   logic [COUNT_FIELD_W-1:0] res_count_ff;
   logic [FIELD_W-1:0]       res_obj_ff, res_x_ff, res_y_ff;
   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic                     rsp_redraw_ff;
   logic [COUNT_FIELD_W-1:0] rsp_count_ff;
   logic [FIELD_W-1:0]       rsp_obj_ff, rsp_x_ff, rsp_y_ff;

   // memory ports
   logic              cnt_we, last_we, ent_we;
   logic [TIDX_W-1:0] cnt_waddr, last_waddr, tile_raddr;
   logic [CNT_W-1:0]  cnt_wdata, last_wdata, cnt_rdata, last_rdata;
   logic [EA_W-1:0]   ent_waddr, ent_raddr;
   logic [ENT_W-1:0]  ent_wdata, ent_rdata;

   // draw checks on the latched request
   logic signed [CW+4:0] right_d, bottom_d, wide_w, wide_h, x_w, y_w;
   logic                 empty_size, clip_out;
   logic [CW-1:0]        left_c, top_c, right_c, bottom_c;

   // divider step
   logic [DIV_W-1:0] trial;
   logic             ge;
   logic [CW-1:0]    rem_nx, tpr_calc;

   // constant divide by the tile size
   logic [RCP_SH-1:0] rcp;
   logic [PROD_W-1:0] cprod;
   logic [DIV_W-1:0]  cquot;

   // per-tile values
   logic [LIN_W-1:0]  lin_idx;
   logic              lin_beyond, tile_ok, slot_ok, full;
   logic [CW+3:0]     px, py, ex_full, ey_full;

   assign x_w      = (CW+5)'(x_ff);
   assign y_w      = (CW+5)'(y_ff);
   assign wide_w   = (CW+5)'({1'b0, width_ff});
   assign wide_h   = (CW+5)'({1'b0, height_ff});
   assign right_d  = x_w + (CW+5)'(w_ff) - (CW+5)'(1);
   assign bottom_d = y_w + (CW+5)'(h_ff) - (CW+5)'(1);
   assign empty_size = (w_ff <= 0) || (h_ff <= 0);
   assign clip_out = (width_ff == '0) || (height_ff == '0) || (x_w >= wide_w) ||
                     (y_w >= wide_h) || (right_d < 0) || (bottom_d < 0);
   assign left_c   = (x_ff < 0) ? '0 : x_ff[CW-1:0];
   assign top_c    = (y_ff < 0) ? '0 : y_ff[CW-1:0];
   assign right_c  = (right_d > wide_w - (CW+5)'(1)) ? width_ff - CW'(1) : right_d[CW-1:0];
   assign bottom_c = (bottom_d > wide_h - (CW+5)'(1)) ? height_ff - CW'(1)
                                                      : bottom_d[CW-1:0];

   assign trial    = {rem_ff, num_ff[DIV_W-1]};
   assign ge       = trial >= {1'b0, den_ff};
   assign rem_nx   = ge ? CW'(trial - {1'b0, den_ff}) : trial[CW-1:0];
   // zero tiles per row reads as one
   assign tpr_calc = (num_ff == '0) ? CW'(1) : num_ff[CW-1:0];

   // row jobs divide by the tile height, the others by the tile width
   assign rcp   = ((job_ff == J_TY0) || (job_ff == J_TY1)) ? RCP_TH : RCP_TW;
   assign cprod = PROD_W'(num_ff) * PROD_W'(rcp);
   assign cquot = cprod[PROD_W-1:RCP_SH];

   assign lin_idx    = row_base_ff + LIN_W'(tx_ff);
   assign lin_beyond = lin_idx >= LIN_W'(MAX_TILES);
   assign tile_ok    = 32'(tile_ff) < 32'(MAX_TILES);
   assign slot_ok    = 32'(slot_ff) < 32'(SLOTS_PER_TILE);
   assign full       = cnt_rdata >= CNT_W'(SLOTS_PER_TILE);
   assign px         = (CW+4)'(tx_ff) * (CW+4)'(TILE_W);
   assign py         = (CW+4)'(ty_ff) * (CW+4)'(TILE_H);
   assign ex_full    = x_ff - px;
   assign ey_full    = y_ff - py;

   // memory port steering
   always_comb begin
      cnt_we     = 1'b0;
      last_we    = 1'b0;
      ent_we     = 1'b0;
      cnt_waddr  = idx_ff;
      last_waddr = idx_ff;
      cnt_wdata  = cnt_rdata + CNT_W'(1);
      last_wdata = last_rdata | CNT_W'(dirty_ff);
      tile_raddr = TIDX_W'(tile_ff);
      ent_waddr  = EA_W'(idx_ff) * EA_W'(SLOTS_PER_TILE) + EA_W'(cnt_rdata);
      ent_wdata  = {id_ff, ex_full[FIELD_W-1:0], ey_full[FIELD_W-1:0]};
      ent_raddr  = EA_W'(TIDX_W'(tile_ff)) * EA_W'(SLOTS_PER_TILE) + EA_W'(slot_ff);
      unique case (state_ff)
         S_CLEAR: begin
            cnt_we     = 1'b1;
            last_we    = 1'b1;
            cnt_waddr  = sweep_ff;
            last_waddr = sweep_ff;
            cnt_wdata  = CNT_W'(1);
            last_wdata = '0;
         end
         S_SWEEP: begin
            last_we    = 1'b1;
            last_waddr = sweep_ff;
            last_wdata = '0;
         end
         S_TILE_RD: begin
            tile_raddr = lin_idx[TIDX_W-1:0];
         end
         S_TILE_WR: begin
            cnt_we  = !full;
            ent_we  = !full;
            last_we = 1'b1;
         end
         S_UPD_WR: begin
            cnt_we     = 1'b1;
            last_we    = 1'b1;
            cnt_waddr  = TIDX_W'(tile_ff);
            last_waddr = TIDX_W'(tile_ff);
            cnt_wdata  = CNT_W'(1);
            last_wdata = cnt_rdata;
         end
         default: begin
         end
      endcase
   end

   tbdt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_TILES)) u_count_ram (
      .clock(clock), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
      .raddr(tile_raddr), .rdata(cnt_rdata)
   );

   tbdt_ram #(.WIDTH(CNT_W), .DEPTH(MAX_TILES)) u_last_ram (
      .clock(clock), .we(last_we), .waddr(last_waddr), .wdata(last_wdata),
      .raddr(tile_raddr), .rdata(last_rdata)
   );

   tbdt_ram #(.WIDTH(ENT_W), .DEPTH(ENT_DEPTH)) u_entry_ram (
      .clock(clock), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
      .raddr(ent_raddr), .rdata(ent_rdata)
   );

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.redraw      = rsp_redraw_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.entry_object = rsp_obj_ff;
   assign rsp_chan.entry_x     = rsp_x_ff;
   assign rsp_chan.entry_y     = rsp_y_ff;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         width_ff     <= CANVAS_W_RESET;
         height_ff    <= CANVAS_H_RESET;
      end else begin
         if (csr_chan.valid && csr_chan.ready) begin
            unique case (csr_reg_type'(csr_chan.index))
               REG_CANVAS_WIDTH:  width_ff  <= csr_chan.data;
               REG_CANVAS_HEIGHT: height_ff <= csr_chan.data;
            endcase
         end
         // done reloads the output register itself
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLEAR, S_SWEEP: begin
               sweep_ff <= sweep_ff + TIDX_W'(1);
               if (sweep_ff == TIDX_W'(MAX_TILES - 1)) begin
                  state_ff <= (state_ff == S_CLEAR) ? S_IDLE : S_DONE;
               end
            end
            S_IDLE: begin
               if (req_chan.valid) begin
                  func_ff       <= func_type'(req_chan.func);
                  x_ff          <= (CW+4)'(req_chan.pos_x) - (CW+4)'(req_chan.anchor_x);
                  y_ff          <= (CW+4)'(req_chan.pos_y) - (CW+4)'(req_chan.anchor_y);
                  w_ff          <= req_chan.obj_width;
                  h_ff          <= req_chan.obj_height;
                  dirty_ff      <= req_chan.obj_dirty;
                  id_ff         <= req_chan.object_id;
                  tile_ff       <= req_chan.tile_index;
                  slot_ff       <= req_chan.slot;
                  res_status_ff <= ST_OK;
                  res_redraw_ff <= 1'b0;
                  res_count_ff  <= '0;
                  res_obj_ff    <= '0;
                  res_x_ff      <= '0;
                  res_y_ff      <= '0;
                  state_ff      <= S_DECODE;
               end
            end
            S_DECODE: begin
               unique case (func_ff)
                  FUNC_DRAW: begin
                     if (empty_size) begin
                        res_status_ff <= ST_EMPTY;
                        state_ff      <= S_DONE;
                     end else if (clip_out) begin
                        res_status_ff <= ST_CLIPPED;
                        state_ff      <= S_DONE;
                     end else begin
                        left_ff   <= left_c;
                        right_ff  <= right_c;
                        top_ff    <= top_c;
                        bottom_ff <= bottom_c;
                        num_ff    <= DIV_W'(width_ff) + DIV_W'(TILE_W - 1);
                        job_ff    <= J_TPR;
                        state_ff  <= S_CDIV;
                     end
                  end
                  FUNC_UPDATE: begin
                     // count and last are read this cycle at the query tile
                     state_ff <= tile_ok ? S_UPD_WR : S_DONE;
                  end
                  FUNC_READ: begin
                     if (!tile_ok || !slot_ok) begin
                        state_ff <= S_DONE;
                     end else if (slot_ff == '0) begin
                        // background slot: tile origin from tile / tiles per row
                        num_ff   <= DIV_W'(width_ff) + DIV_W'(TILE_W - 1);
                        job_ff   <= J_TPR;
                        state_ff <= S_CDIV;
                     end else begin
                        state_ff <= S_ENT_WAIT;
                     end
                  end
                  FUNC_REDRAW_ALL: begin
                     sweep_ff <= '0;
                     state_ff <= S_SWEEP;
                  end
               endcase
            end
            S_CDIV: begin
               // divide by the tile size through the reciprocal
               num_ff   <= cquot;
               state_ff <= S_DIV_NEXT;
            end
            S_DIV: begin
               // restoring divider, one quotient bit per cycle
               rem_ff  <= rem_nx;
               num_ff  <= {num_ff[DIV_W-2:0], ge};
               dcnt_ff <= dcnt_ff + DCNT_W'(1);
               if (dcnt_ff == DCNT_W'(DIV_W - 1)) begin
                  state_ff <= S_DIV_NEXT;
               end
            end
            S_DIV_NEXT: begin
               rem_ff  <= '0;
               dcnt_ff <= '0;
               unique case (job_ff)
                  J_TPR: begin
                     tpr_ff <= tpr_calc;
                     if (func_ff == FUNC_DRAW) begin
                        num_ff   <= DIV_W'(left_ff);
                        job_ff   <= J_TX0;
                        state_ff <= S_CDIV;
                     end else begin
                        num_ff   <= DIV_W'(tile_ff);
                        den_ff   <= tpr_calc;
                        job_ff   <= J_TILE;
                        state_ff <= S_DIV;
                     end
                  end
                  J_TX0: begin
                     tx0_ff   <= num_ff[CW-1:0];
                     num_ff   <= DIV_W'(right_ff);
                     job_ff   <= J_TX1;
                     state_ff <= S_CDIV;
                  end
                  J_TX1: begin
                     tx1_ff   <= num_ff[CW-1:0];
                     num_ff   <= DIV_W'(top_ff);
                     job_ff   <= J_TY0;
                     state_ff <= S_CDIV;
                  end
                  J_TY0: begin
                     ty_ff    <= num_ff[CW-1:0];
                     num_ff   <= DIV_W'(bottom_ff);
                     job_ff   <= J_TY1;
                     state_ff <= S_CDIV;
                  end
                  J_TY1: begin
                     ty1_ff   <= num_ff[CW-1:0];
                     state_ff <= S_ROWBASE;
                  end
                  J_TILE: begin
                     res_x_ff <= FIELD_W'(32'(rem_ff) * 32'(TILE_W));
                     res_y_ff <= FIELD_W'(32'(num_ff) * 32'(TILE_H));
                     state_ff <= S_DONE;
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_ROWBASE: begin
               row_base_ff <= LIN_W'(ty_ff) * LIN_W'(tpr_ff);
               tx_ff       <= tx0_ff;
               state_ff    <= S_TILE_RD;
            end
            S_TILE_RD: begin
               // tiles past the store end the walk; later ones lie further out
               if (lin_beyond) begin
                  res_status_ff <= ST_OVERFLOW;
                  state_ff      <= S_DONE;
               end else begin
                  idx_ff   <= lin_idx[TIDX_W-1:0];
                  state_ff <= S_TILE_WR;
               end
            end
            S_TILE_WR: begin
               if (full) begin
                  res_status_ff <= ST_OVERFLOW;
               end
               state_ff <= S_TILE_RD;
               if (tx_ff == tx1_ff) begin
                  if (ty_ff == ty1_ff) begin
                     state_ff <= S_DONE;
                  end else begin
                     ty_ff       <= ty_ff + CW'(1);
                     tx_ff       <= tx0_ff;
                     row_base_ff <= row_base_ff + LIN_W'(tpr_ff);
                  end
               end else begin
                  tx_ff <= tx_ff + CW'(1);
               end
            end
            S_UPD_WR: begin
               res_redraw_ff <= (cnt_rdata != last_rdata);
               res_count_ff  <= COUNT_FIELD_W'(cnt_rdata);
               state_ff      <= S_DONE;
            end
            S_ENT_WAIT: begin
               res_obj_ff <= ent_rdata[ENT_W-1:2*FIELD_W];
               res_x_ff   <= ent_rdata[2*FIELD_W-1:FIELD_W];
               res_y_ff   <= ent_rdata[FIELD_W-1:0];
               state_ff   <= S_DONE;
            end
            S_DONE: begin
               // hand over once the output register is free
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_redraw_ff <= res_redraw_ff;
                  rsp_count_ff  <= res_count_ff;
                  rsp_obj_ff    <= res_obj_ff;
                  rsp_x_ff      <= res_x_ff;
                  rsp_y_ff      <= res_y_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`include "tile_binning_dirty_tracker_unit_assert.svh"

   `TBDT_ASSERT_NXT(a_accept_busy, req_chan.valid && req_chan.ready, state_ff != S_IDLE, "no start")
   `TBDT_ASSERT_IMP(a_entry_write_in_walk, ent_we, state_ff == S_TILE_WR, "stray entry write")
   `TBDT_ASSERT_IMP(a_count_bounded, cnt_we, cnt_wdata <= CNT_W'(SLOTS_PER_TILE), "count overrun")
   `TBDT_ASSERT_IMP(a_rsp_from_done, $rose(rsp_valid_ff), $past(state_ff) == S_DONE, "rsp not from done")

endmodule
